// ===== src/bltd_pkg.sv =====
// Package for the byte level token text decoder: field widths, the UTF-8 lead
// byte decode and the code point to raw byte map with its remap table.
// No dependencies.
package bltd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LimitW = 16;
  localparam int unsigned PointW = 21;
  localparam int unsigned LenW   = 3;

  localparam logic [ByteW-1:0] QuestionMark = 8'h3F;
  localparam logic [LimitW-1:0] LimitReset  = 16'hFFFF;

  localparam int unsigned RemapDepth = 35;
  localparam logic [ByteW-1:0] HighRemap [RemapDepth] = '{
    8'h7F, 8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88,
    8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91, 8'h92,
    8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9A, 8'h9B, 8'h9C,
    8'h9D, 8'h9E, 8'h9F, 8'hA0, 8'hAD
  };

  typedef logic [ByteW-1:0] byte_t;
  typedef byte_t char_bytes_t [4];

  typedef struct packed {
    logic  hit;
    byte_t value;
  } map_res_t;

  function automatic logic [LenW-1:0] lead_len(input byte_t b);
    logic [LenW-1:0] len;
    if (!b[7]) begin
      len = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

  function automatic logic [PointW-1:0] assemble_point(input char_bytes_t c,
                                                       input logic [LenW-1:0] len);
    logic [PointW-1:0] cp;
    case (len)
      3'd1: cp = PointW'(c[0]);
      3'd2: cp = PointW'({c[0][4:0], c[1][5:0]});
      3'd3: cp = PointW'({c[0][3:0], c[1][5:0], c[2][5:0]});
      default: cp = {c[0][2:0], c[1][5:0], c[2][5:0], c[3][5:0]};
    endcase
    return cp;
  endfunction

  function automatic map_res_t map_point(input logic [PointW-1:0] cp);
    map_res_t res;
    logic [PointW-1:0] k;
    k = cp - PointW'(21'h121);
    res.hit   = 1'b1;
    res.value = cp[7:0];
    if (cp inside {[21'h21 : 21'h7E], [21'hA1 : 21'hAC], [21'hAE : 21'h120]}) begin
      res.value = cp[7:0];
    end else if (cp inside {[21'h121 : 21'h143]}) begin
      res.value = HighRemap[k[5:0]];
    end else if (cp == 21'h144) begin
      res.value = QuestionMark;
    end else begin
      res.hit = 1'b0;
    end
    return res;
  endfunction

endpackage

// ===== src/byte_level_token_text_decoder_unit.sv =====
// Top level of the byte level token text decoder.
// Depends on bltd_pkg for the lead byte decode and the code point map.
//
// Usage: token text arrives as one UTF-8 byte per beat on the s_axis channel,
// with s_axis_tlast on the last byte of a text. Each complete character is
// mapped back to one raw byte, or passed through as its original one to four
// bytes. Results leave on m_axis, one byte per beat, with the running count
// of bytes of this text; m_axis_tlast marks the last result of an input byte
// or the result that reaches the limit. The cfg channel writes the per text
// output limit; it is always ready, and is to be written only while the block
// is idle; the block itself does not enforce this. A result passes through the
// input register, the run register and the output register.
// Throughput: one input byte per cycle while the receiver is ready and each
// character yields at most one result; a pass-through character holds the
// run register until all its bytes are sent, so the emitter, one byte a cycle,
// sets the rate. Bytes dropped at the limit still pass through the emitter.
// Reset clears all control state and sets the limit to 65535. When the
// receiver stalls, the output register holds, the run register and the input
// register fill, and s_axis_tready falls.
module byte_level_token_text_decoder_unit
  import bltd_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [LimitW-1:0] cfg_data_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,  // [7:0] in_byte
  input  logic              s_axis_tlast,  // end_of_text
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,  // [7:0] out_byte, [23:8] out_count
  output logic              m_axis_tlast   // run_last
);

  localparam int unsigned LW = (COUNT_WIDTH > LimitW) ? COUNT_WIDTH : LimitW;

  logic [LimitW-1:0] limit_q;
  logic [LW-1:0]     lim_ext, cap_ext, lim_eff;

  logic  in_vld_q, in_eot_q;
  byte_t in_byte_q;

  char_bytes_t       char_q;
  logic [1:0]        held_q, held_d;
  logic [LenW-1:0]   needed_q, needed_d;

  logic              run_vld_q, run_eot_q;
  byte_t             run_byte_q [4];
  logic [LenW-1:0]   run_len_q;
  logic [1:0]        run_idx_q;

  logic [COUNT_WIDTH-1:0] count_q, count_d, count_n;
  logic                   full_q, full_d;

  logic              out_vld_q, out_last_q;
  byte_t             out_byte_q;
  logic [LimitW-1:0] out_count_q;

  logic              start, complete, load_s, step_s, emit_s, out_free, run_free;
  logic              last_in_run, blocked, hit_lim, clr;
  logic [LenW-1:0]   need, held_n, run_len_d;
  char_bytes_t       chars_w;
  char_bytes_t       run_bytes_w;
  logic [PointW-1:0] cp;
  map_res_t          map_r;

  assign cfg_ready_o = 1'b1;

  assign lim_ext = LW'(limit_q);
  assign cap_ext = LW'({COUNT_WIDTH{1'b1}});
  assign lim_eff = (lim_ext < cap_ext) ? lim_ext : cap_ext;

  assign out_free    = !out_vld_q || m_axis_tready;
  assign step_s      = run_vld_q && out_free;
  assign last_in_run = (LenW'(run_idx_q) + LenW'(1)) == run_len_q;
  assign run_free    = !run_vld_q || (step_s && last_in_run);
  assign load_s      = in_vld_q && run_free;

  assign s_axis_tready = !in_vld_q || load_s;

  always_comb begin
    start   = (held_q == 2'd0);
    need    = start ? lead_len(in_byte_q) : needed_q;
    chars_w = char_q;
    chars_w[held_q] = in_byte_q;
    held_n   = LenW'(held_q) + LenW'(1);
    complete = (held_n >= need);
    cp       = assemble_point(chars_w, need);
    map_r    = map_point(cp);
    run_len_d = map_r.hit ? LenW'(1) : need;
    run_bytes_w = chars_w;
    if (map_r.hit) begin
      run_bytes_w[0] = map_r.value;
    end
    if (complete || in_eot_q) begin
      held_d   = 2'd0;
      needed_d = '0;
    end else begin
      held_d   = held_n[1:0];
      needed_d = need;
    end
  end

  always_comb begin
    blocked = full_q || (LW'(count_q) >= lim_eff);
    emit_s  = step_s && !blocked;
    count_n = count_q + COUNT_WIDTH'(1);
    hit_lim = (LW'(count_n) >= lim_eff);
    clr     = (step_s && last_in_run && run_eot_q) || (load_s && !complete && in_eot_q);
    count_d = emit_s ? count_n : count_q;
    full_d  = step_s ? (blocked || hit_lim) : full_q;
    if (clr) begin
      count_d = '0;
      full_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= LimitReset;
      in_vld_q  <= 1'b0;
      held_q    <= 2'd0;
      needed_q  <= '0;
      run_vld_q <= 1'b0;
      run_idx_q <= 2'd0;
      count_q   <= '0;
      full_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (load_s) begin
        held_q    <= held_d;
        needed_q  <= needed_d;
        run_vld_q <= complete;
        run_idx_q <= 2'd0;
      end else if (step_s) begin
        if (last_in_run) begin
          run_vld_q <= 1'b0;
        end else begin
          run_idx_q <= run_idx_q + 2'd1;
        end
      end
      count_q <= count_d;
      full_q  <= full_d;
      if (out_free) begin
        out_vld_q <= emit_s;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_eot_q  <= s_axis_tlast;
    end
    if (load_s) begin
      char_q[held_q] <= in_byte_q;
      run_eot_q      <= in_eot_q;
      run_len_q      <= run_len_d;
      run_byte_q     <= run_bytes_w;
    end
    if (emit_s) begin
      out_byte_q  <= run_byte_q[run_idx_q];
      out_last_q  <= last_in_run || hit_lim;
      out_count_q <= LimitW'(LW'(count_n));
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_count_q, out_byte_q};
  assign m_axis_tlast  = out_last_q;

  a_run_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_vld_q |-> (LenW'(run_idx_q) < run_len_q))
    else $error("Run index has passed the run length.");

  a_held_below_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q != 2'd0) |-> (LenW'(held_q) < needed_q))
    else $error("Gathered bytes reached the character length without completing.");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_count_q != '0 || COUNT_WIDTH > LimitW))
    else $error("A result beat carries a zero byte count.");

  a_no_emit_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_q && step_s && !clr) |=> full_q)
    else $error("Output full flag cleared without end of text.");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for byte_level_token_text_decoder_unit: directed and random token text,
// checked beat by beat against a decoder model held in this file.
// Depends on bltd_pkg and the top level of the block; reads no files.
module tb;
  import bltd_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 16;

  typedef struct packed {
    byte_t             value;
    logic              last;
    logic [LimitW-1:0] count;
  } out_beat_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [LimitW-1:0] cfg_data_i    = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = '0;
  logic              s_axis_tlast  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;
  logic              m_axis_tlast;

  logic [LimitW-1:0] limit_q = LimitReset;
  byte_t             char_buf [4];
  int                need_len = 0;
  int                held_len = 0;
  int                emitted  = 0;
  bit                full     = 1'b0;
  out_beat_t         expected_q [$];
  byte_t             text_q [$];
  int                errors     = 0;
  int                items_sent = 0;
  bit                steady     = 1'b0;
  int unsigned       cycle_count = 0;

  byte_level_token_text_decoder_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  function automatic int lead_bytes(byte_t b);
    if (b < 8'h80) begin
      return 1;
    end else if (b[7:5] == 3'b110) begin
      return 2;
    end else if (b[7:4] == 4'b1110) begin
      return 3;
    end
    return 4;
  endfunction

  // Raw byte that a code point stands for, or -1 when the character passes through.
  function automatic int raw_byte_of(int cp);
    if ((cp >= 'h21 && cp <= 'h7E) || (cp >= 'hA1 && cp <= 'hAC) ||
        (cp >= 'hAE && cp <= 'hFF)) begin
      return cp;
    end else if (cp >= 'h100 && cp <= 'h120) begin
      return cp - 'h100;
    end else if (cp >= 'h121 && cp <= 'h142) begin
      return 'h7F + cp - 'h121;
    end else if (cp == 'h143) begin
      return 'hAD;
    end else if (cp == 'h144) begin
      return int'(QuestionMark);
    end
    return -1;
  endfunction

  task automatic predict_decode(byte_t b, bit eot);
    out_beat_t run [$];
    byte_t     vals [4];
    int        nvals;
    int        cp;
    int        raw;
    if (held_len == 0 || held_len >= 4) begin
      held_len = 0;
      need_len = lead_bytes(b);
    end
    char_buf[held_len & 3] = b;
    held_len++;
    if (held_len >= need_len) begin
      case (need_len)
        1: begin
          cp = char_buf[0];
        end
        2: begin
          cp = {char_buf[0][4:0], char_buf[1][5:0]};
        end
        3: begin
          cp = {char_buf[0][3:0], char_buf[1][5:0], char_buf[2][5:0]};
        end
        default: begin
          cp = {char_buf[0][2:0], char_buf[1][5:0], char_buf[2][5:0], char_buf[3][5:0]};
        end
      endcase
      raw = raw_byte_of(cp);
      if (raw >= 0) begin
        vals[0] = byte_t'(raw);
        nvals = 1;
      end else begin
        for (int k = 0; k < need_len; k++) vals[k] = char_buf[k];
        nvals = need_len;
      end
      for (int k = 0; k < nvals; k++) begin
        if (full || emitted >= limit_q) begin
          full = 1'b1;
        end else begin
          emitted++;
          if (emitted >= limit_q) full = 1'b1;
          run.push_back('{vals[k], 1'b0, LimitW'(emitted)});
        end
      end
      held_len = 0;
      need_len = 0;
    end
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) expected_q.push_back(run[i]);
    if (eot) begin
      held_len = 0;
      need_len = 0;
      emitted  = 0;
      full     = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $error("Unexpected beat: out_byte %h out_count %0d", m_axis_tdata[7:0],
               m_axis_tdata[23:8]);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata[7:0] !== want.value) begin
          $error("out_byte: expected %h, got %h", want.value, m_axis_tdata[7:0]);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("run_last: expected %b, got %b", want.last, m_axis_tlast);
          errors++;
        end
        if (m_axis_tdata[23:8] !== want.count) begin
          $error("out_count: expected %0d, got %0d", want.count, m_axis_tdata[23:8]);
          errors++;
        end
      end
    end
  end

  initial begin
    int n;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        @(negedge clk_i) m_axis_tready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end
      @(negedge clk_i) m_axis_tready <= 1'b1;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
  end

  task automatic send_byte(byte_t b, bit eot);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i) s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eot;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_decode(b, eot);
    items_sent++;
  endtask

  task automatic send_text(bit close);
    foreach (text_q[i]) send_byte(text_q[i], close && i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic wait_idle();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [LimitW-1:0] v);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    limit_q = v;
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  task automatic add_point(int cp);
    if (cp < 'h80) begin
      text_q.push_back(byte_t'(cp));
    end else if (cp < 'h800) begin
      text_q.push_back(byte_t'('hC0 | (cp >> 6)));
      text_q.push_back(byte_t'('h80 | (cp & 'h3F)));
    end else if (cp < 'h10000) begin
      text_q.push_back(byte_t'('hE0 | (cp >> 12)));
      text_q.push_back(byte_t'('h80 | ((cp >> 6) & 'h3F)));
      text_q.push_back(byte_t'('h80 | (cp & 'h3F)));
    end else begin
      text_q.push_back(byte_t'('hF0 | (cp >> 18)));
      text_q.push_back(byte_t'('h80 | ((cp >> 12) & 'h3F)));
      text_q.push_back(byte_t'('h80 | ((cp >> 6) & 'h3F)));
      text_q.push_back(byte_t'('h80 | (cp & 'h3F)));
    end
  endtask

  // Mostly well-formed characters around the mapped ranges, with some stray bytes
  // and now and then a character cut off by the end of the text.
  task automatic random_text();
    int r;
    repeat ($urandom_range(1, 10)) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        add_point($urandom_range(0, 'h7F));
      end else if (r < 65) begin
        add_point($urandom_range('h80, 'h150));
      end else if (r < 75) begin
        add_point($urandom_range('h151, 'h7FF));
      end else if (r < 83) begin
        add_point($urandom_range('h800, 'hFFFF));
      end else if (r < 90) begin
        add_point($urandom_range('h10000, 'h1FFFFF));
      end else begin
        text_q.push_back(byte_t'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      add_point($urandom_range('h800, 'h1FFFFF));
      repeat ($urandom_range(1, 3)) void'(text_q.pop_back());
    end
    send_text(1'b1);
  endtask

  task automatic run_random(int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) random_text();
  endtask

  task automatic test_mapped_ranges();
    text_q = '{8'h21, 8'h7E, 8'hC2, 8'hA1, 8'hC4, 8'h80, 8'hC4, 8'hA0,
               8'hC4, 8'hA1, 8'hC5, 8'h83, 8'hC5, 8'h84};
    send_text(1'b1);
  endtask

  task automatic test_pass_through();
    text_q = '{8'h00, 8'hC2, 8'hAD, 8'hF0, 8'h9F, 8'h98, 8'h80};
    send_text(1'b1);
  endtask

  task automatic test_cut_off_character();
    text_q = '{8'hE2, 8'h82};
    send_text(1'b1);
  endtask

  task automatic test_limit_below_count();
    text_q = '{8'h41, 8'h42, 8'h43, 8'h44, 8'h45};
    send_text(1'b0);
    write_limit(16'd3);
    text_q = '{8'h46, 8'h47};
    send_text(1'b1);
    write_limit(16'd2);
    text_q = '{8'h61, 8'h62, 8'h63};
    send_text(1'b1);
  endtask

  task automatic test_random_limits();
    write_limit(LimitReset);
    steady = 1'b1;
    run_random(60);
    steady = 1'b0;
    run_random(100);
    write_limit(16'd0);
    run_random(40);
    write_limit(16'd1);
    run_random(40);
    write_limit(LimitW'($urandom_range(2, 6)));
    run_random(60);
    write_limit(LimitW'($urandom_range(7, 20)));
    run_random(60);
    write_limit(LimitReset);
    run_random(50);
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_mapped_ranges();
    test_pass_through();
    test_cut_off_character();
    test_limit_below_count();
    test_random_limits();
    wait_idle();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
